@@ design/jet_pkg.sv @@
`default_nettype none

package jet_pkg;

    // field widths
    localparam int COORD_W    = 14;
    localparam int SIDE_W     = 15;
    localparam int ITER_BITS  = 10;
    localparam int WORD_W     = 32;
    localparam int COLOR_W    = 8;
    localparam int PAL_IDX_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // magnitude of scale * (p - side/2), scale at most 3
    localparam int MAG_W = COORD_W + 2;

    // default fixed point format of z and c
    localparam int FRACTION_BITS_DEF = 28;

    // palette steps
    localparam logic [COLOR_W-1:0] PAL_STEP_RG = 8'd36;
    localparam logic [COLOR_W-1:0] PAL_STEP_B  = 8'd85;

    // register indexes
    typedef logic [CFG_IDX_W-1:0] cfg_index_t;
    localparam cfg_index_t CFG_C_REAL   = 3'd0;
    localparam cfg_index_t CFG_C_IMAG   = 3'd1;
    localparam cfg_index_t CFG_MAX_ITER = 3'd2;
    localparam cfg_index_t CFG_WIDTH    = 3'd3;
    localparam cfg_index_t CFG_HEIGHT   = 3'd4;

    // register reset values
    localparam logic signed [WORD_W-1:0] C_REAL_RST   = -32'sd187904819;
    localparam logic signed [WORD_W-1:0] C_IMAG_RST   = 32'sd72517838;
    localparam logic [ITER_BITS-1:0]     MAX_ITER_RST = 10'd1000;
    localparam logic [SIDE_W-1:0]        WIDTH_RST    = 15'd10000;
    localparam logic [SIDE_W-1:0]        HEIGHT_RST   = 15'd10000;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START_X,
        ST_WAIT_X,
        ST_WAIT_Y,
        ST_MUL,
        ST_UPD,
        ST_OUT
    } jet_state_t;

    // controller to datapath
    typedef struct packed {
        logic load_pixel;
        logic div_start;
        logic div_sel_y;
        logic cap_re;
        logic cap_im;
        logic init_left;
        logic mul;
        logic upd;
        logic load_out;
    } jet_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic left_zero;
        logic escaped;
    } jet_sts_t;

endpackage

`default_nettype wire

@@ design/jet_if.sv @@
`default_nettype none

// pixel request channel
interface jet_pix_if;
    logic                         valid;
    logic                         ready;
    logic [jet_pkg::COORD_W-1:0]  pixel_x;
    logic [jet_pkg::COORD_W-1:0]  pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

// escape result channel
interface jet_res_if;
    logic                          valid;
    logic                          ready;
    logic [jet_pkg::COORD_W-1:0]   out_x;
    logic [jet_pkg::COORD_W-1:0]   out_y;
    logic [jet_pkg::ITER_BITS-1:0] iterations_left;
    logic [jet_pkg::COLOR_W-1:0]   red;
    logic [jet_pkg::COLOR_W-1:0]   green;
    logic [jet_pkg::COLOR_W-1:0]   blue;

    modport source (output valid, output out_x, output out_y, output iterations_left,
                    output red, output green, output blue, input ready);
    modport sink   (input valid, input out_x, input out_y, input iterations_left,
                    input red, input green, input blue, output ready);
endinterface

// register write channel
interface jet_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [jet_pkg::CFG_IDX_W-1:0]  index;
    logic [jet_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ design/julia_escape_time_pixel.sv @@
// Julia set escape-time engine, one pixel per item.
// pix: pixel_x/pixel_y request, taken while the engine is idle.
// res: pixel echo, iterations_left and an RGB palette color.
// cfg: register writes (index 0 c_real, 1 c_imag, 2 max_iterations,
//      3 image_width, 4 image_height), ready is always high; write only
//      while no item is in flight.
// no new item is taken until the result of the last one is loaded; the
//      next item can be taken in the cycle after the result is loaded.
// the two coordinate divisions run one quotient bit per cycle on a single
//      shared divider; each iteration forms the three 32x32 products in
//      ST_MUL and does the escape test and the update of z in ST_UPD.
// a stalled receiver holds the finished result in the output register; a
//      following item is still accepted and worked on, and waits at the
//      end until the output register is free.
// reset clears the controller, the divider flags, the budget counter and the
//      result flag, and returns the config registers to their defaults.
`default_nettype none

module julia_escape_time_pixel #(
    parameter int FRACTION_BITS = jet_pkg::FRACTION_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    jet_pix_if.sink      pix,
    jet_res_if.source    res,
    jet_cfg_if.sink      cfg
);

    jet_pkg::jet_cmd_t cmd;
    jet_pkg::jet_sts_t sts;

    // sequencer
    jet_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pix.valid),
        .in_ready  (pix.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // arithmetic and registers
    jet_datapath #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg.valid),
        .cfg_ready       (cfg.ready),
        .cfg_index       (cfg.index),
        .cfg_data        (cfg.data),
        .pixel_x         (pix.pixel_x),
        .pixel_y         (pix.pixel_y),
        .out_x           (res.out_x),
        .out_y           (res.out_y),
        .iterations_left (res.iterations_left),
        .red             (res.red),
        .green           (res.green),
        .blue            (res.blue),
        .cmd             (cmd),
        .sts             (sts)
    );

`ifndef SYNTH
    // an accepted item keeps the engine busy in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (pix.valid && pix.ready) |=> !pix.ready)
        else $error("input ready right after an accepted item");

    // a divider start clears its done flag
    a_div_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> !sts.div_done)
        else $error("divider done flag survived a start");

    // no iteration is started with the budget spent
    a_mul_budget: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul |-> !sts.left_zero)
        else $error("iteration started with zero budget");

    // loading the result register presents a result
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> res.valid)
        else $error("result loaded but not presented");
`endif

endmodule

`default_nettype wire

@@ design/jet_div.sv @@
`default_nettype none

// one quotient bit per cycle, signed result saturated to 32 bits
module jet_div #(
    parameter int NUM_W = 44,
    parameter int DEN_W = 15
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [NUM_W-1:0]        num,
    input  logic [DEN_W-1:0]        den,
    input  logic                    neg,
    output logic                    done,
    output logic signed [31:0]      quot
);

    localparam int CNT_W = $clog2(NUM_W);
    localparam int QW    = (NUM_W > 33) ? NUM_W : 33;

    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   trial_sub;
    logic             qbit;
    logic [QW-1:0]    q_w;
    logic             pos_over;
    logic             neg_over;

    // restoring step
    always_comb
    begin
        trial     = {rem_reg, num_reg[NUM_W-1]};
        trial_sub = trial - {1'b0, den_reg};
        qbit      = (trial >= {1'b0, den_reg});
        rem_next  = qbit ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
        num_next  = {num_reg[NUM_W-2:0], qbit};
        cnt_next  = cnt_reg - 1'b1;
        busy_next = busy_reg && (cnt_reg != '0);
        done_next = done_reg || (busy_reg && (cnt_reg == '0));
    end

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(NUM_W - 1);
        end
        else if (busy_reg)
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operands and partial quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
            neg_reg <= neg;
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    // sign and saturation
    always_comb
    begin
        q_w      = QW'(num_reg);
        pos_over = (q_w > QW'(33'h07FFFFFFF));
        neg_over = (q_w > QW'(33'h080000000));
        if (neg_reg)
            quot = neg_over ? 32'sh80000000 : $signed(-q_w[31:0]);
        else
            quot = pos_over ? 32'sh7FFFFFFF : $signed(q_w[31:0]);
    end

    assign done = done_reg;

endmodule

`default_nettype wire

@@ design/jet_datapath.sv @@
`default_nettype none

module jet_datapath #(
    parameter int FRACTION_BITS = jet_pkg::FRACTION_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // register writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [jet_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [jet_pkg::CFG_DATA_W-1:0]   cfg_data,
    // pixel payload
    input  logic [jet_pkg::COORD_W-1:0]      pixel_x,
    input  logic [jet_pkg::COORD_W-1:0]      pixel_y,
    // result payload
    output logic [jet_pkg::COORD_W-1:0]      out_x,
    output logic [jet_pkg::COORD_W-1:0]      out_y,
    output logic [jet_pkg::ITER_BITS-1:0]    iterations_left,
    output logic [jet_pkg::COLOR_W-1:0]      red,
    output logic [jet_pkg::COLOR_W-1:0]      green,
    output logic [jet_pkg::COLOR_W-1:0]      blue,
    // controller link
    input  jet_pkg::jet_cmd_t                cmd,
    output jet_pkg::jet_sts_t                sts
);

    localparam int NUM_W = jet_pkg::MAG_W + FRACTION_BITS;
    localparam int W     = jet_pkg::WORD_W;
    localparam logic [63:0]        ESC_LIMIT = 64'd4 << (2 * FRACTION_BITS);
    localparam logic signed [63:0] S32_MAX   = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN   = -64'sd2147483648;

    function automatic logic signed [W-1:0] sat32(input logic signed [63:0] v);
        logic signed [W-1:0] r;
        if (v > S32_MAX)
            r = S32_MAX[W-1:0];
        else if (v < S32_MIN)
            r = S32_MIN[W-1:0];
        else
            r = v[W-1:0];
        return r;
    endfunction

    // configuration registers
    logic signed [W-1:0]              c_real_reg;
    logic signed [W-1:0]              c_imag_reg;
    logic [jet_pkg::ITER_BITS-1:0]    max_iter_reg;
    logic [jet_pkg::SIDE_W-1:0]       width_reg;
    logic [jet_pkg::SIDE_W-1:0]       height_reg;

    // pixel and iteration state
    logic [jet_pkg::COORD_W-1:0]      px_reg;
    logic [jet_pkg::COORD_W-1:0]      py_reg;
    logic signed [W-1:0]              re_reg, re_next;
    logic signed [W-1:0]              im_reg, im_next;
    logic signed [63:0]               rr_reg, ii_reg, ri_reg;
    logic [jet_pkg::ITER_BITS-1:0]    left_reg;

    // result registers
    logic [jet_pkg::COORD_W-1:0]      out_x_reg, out_y_reg;
    logic [jet_pkg::ITER_BITS-1:0]    left_out_reg;
    logic [jet_pkg::COLOR_W-1:0]      red_reg, green_reg, blue_reg;

    // mapping operands
    logic [jet_pkg::COORD_W-1:0]      map_p;
    logic [jet_pkg::SIDE_W-1:0]       map_side;
    logic [jet_pkg::SIDE_W-1:0]       map_s;
    logic signed [jet_pkg::MAG_W-1:0] map_d;
    logic signed [jet_pkg::MAG_W-1:0] map_dneg;
    logic [jet_pkg::COORD_W-1:0]      map_dmag;
    logic [jet_pkg::MAG_W-1:0]        map_mag;
    logic                             map_neg;
    logic [NUM_W-1:0]                 div_num;
    logic                             div_done;
    logic signed [W-1:0]              div_quot;

    // step arithmetic
    logic signed [63:0]               rr_w, ii_w, ri_w;
    logic [63:0]                      mag_sum;
    logic signed [63:0]               diff;
    logic signed [63:0]               sum_re, sum_im;
    logic signed [63:0]               c_re_ext, c_im_ext;
    logic [jet_pkg::PAL_IDX_W-1:0]    pal_idx;

    assign cfg_ready = 1'b1;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_real_reg   <= jet_pkg::C_REAL_RST;
            c_imag_reg   <= jet_pkg::C_IMAG_RST;
            max_iter_reg <= jet_pkg::MAX_ITER_RST;
            width_reg    <= jet_pkg::WIDTH_RST;
            height_reg   <= jet_pkg::HEIGHT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                jet_pkg::CFG_C_REAL:   c_real_reg   <= $signed(cfg_data[W-1:0]);
                jet_pkg::CFG_C_IMAG:   c_imag_reg   <= $signed(cfg_data[W-1:0]);
                jet_pkg::CFG_MAX_ITER: max_iter_reg <= cfg_data[jet_pkg::ITER_BITS-1:0];
                jet_pkg::CFG_WIDTH:    width_reg    <= cfg_data[jet_pkg::SIDE_W-1:0];
                jet_pkg::CFG_HEIGHT:   height_reg   <= cfg_data[jet_pkg::SIDE_W-1:0];
                default: ;
            endcase
        end
    end

    // scaled offset from image center, sign kept apart
    always_comb
    begin
        map_p    = cmd.div_sel_y ? py_reg : px_reg;
        map_side = cmd.div_sel_y ? height_reg : width_reg;
        map_s    = (map_side == '0) ? jet_pkg::SIDE_W'(1) : map_side;
        map_d    = $signed({2'b00, map_p}) - $signed({2'b00, map_s[jet_pkg::SIDE_W-1:1]});
        map_dneg = -map_d;
        map_neg  = map_d[jet_pkg::MAG_W-1];
        map_dmag = map_neg ? map_dneg[jet_pkg::COORD_W-1:0] : map_d[jet_pkg::COORD_W-1:0];
        if (cmd.div_sel_y)
            map_mag = {map_dmag, 1'b0} + jet_pkg::MAG_W'(0);
        else
            map_mag = {map_dmag, 1'b0} + jet_pkg::MAG_W'(map_dmag);
        div_num  = {map_mag, {FRACTION_BITS{1'b0}}};
    end

    jet_div #(
        .NUM_W (NUM_W),
        .DEN_W (jet_pkg::SIDE_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (map_s),
        .neg   (map_neg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // products of z
    assign rr_w = re_reg * re_reg;
    assign ii_w = im_reg * im_reg;
    assign ri_w = re_reg * im_reg;

    // escape test and next z
    always_comb
    begin
        c_re_ext = 64'(c_real_reg);
        c_im_ext = 64'(c_imag_reg);
        mag_sum  = $unsigned(rr_reg) + $unsigned(ii_reg);
        diff     = rr_reg - ii_reg;
        sum_re   = (diff >>> FRACTION_BITS) + c_re_ext;
        sum_im   = (ri_reg >>> (FRACTION_BITS - 1)) + c_im_ext;
        re_next  = sat32(sum_re);
        im_next  = sat32(sum_im);
    end

    // iteration state
    always_ff @(posedge clk)
    begin
        if (cmd.load_pixel)
        begin
            px_reg <= pixel_x;
            py_reg <= pixel_y;
        end
        if (cmd.cap_re)
            re_reg <= div_quot;
        else if (cmd.upd)
            re_reg <= re_next;
        if (cmd.cap_im)
            im_reg <= div_quot;
        else if (cmd.upd)
            im_reg <= im_next;
        if (cmd.mul)
        begin
            rr_reg <= rr_w;
            ii_reg <= ii_w;
            ri_reg <= ri_w;
        end
    end

    // budget counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            left_reg <= '0;
        else if (cmd.init_left)
            left_reg <= max_iter_reg;
        else if (cmd.upd)
            left_reg <= left_reg - 1'b1;
    end

    // palette and result register
    assign pal_idx = left_reg[jet_pkg::PAL_IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_x_reg    <= px_reg;
            out_y_reg    <= py_reg;
            left_out_reg <= left_reg;
            red_reg      <= jet_pkg::COLOR_W'(pal_idx[7:5]) * jet_pkg::PAL_STEP_RG;
            green_reg    <= jet_pkg::COLOR_W'(pal_idx[5:3]) * jet_pkg::PAL_STEP_RG;
            blue_reg     <= jet_pkg::COLOR_W'(pal_idx[1:0]) * jet_pkg::PAL_STEP_B;
        end
    end

    assign out_x           = out_x_reg;
    assign out_y           = out_y_reg;
    assign iterations_left = left_out_reg;
    assign red             = red_reg;
    assign green           = green_reg;
    assign blue            = blue_reg;

    assign sts.div_done  = div_done;
    assign sts.left_zero = (left_reg == '0);
    assign sts.escaped   = (mag_sum >= ESC_LIMIT);

endmodule

`default_nettype wire

@@ design/jet_ctrl.sv @@
`default_nettype none

module jet_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  jet_pkg::jet_sts_t sts,
    output jet_pkg::jet_cmd_t cmd
);

    jet_pkg::jet_state_t state_reg, state_next;
    logic                out_valid_reg, out_valid_next;
    logic                slot_free;

    // state and result flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= jet_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign slot_free = !out_valid_reg || out_ready;

    // sequencing
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            jet_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_pixel = 1'b1;
                    state_next     = jet_pkg::ST_START_X;
                end
            end
            jet_pkg::ST_START_X:
            begin
                cmd.div_start = 1'b1;
                state_next    = jet_pkg::ST_WAIT_X;
            end
            jet_pkg::ST_WAIT_X:
            begin
                if (sts.div_done)
                begin
                    cmd.cap_re    = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel_y = 1'b1;
                    state_next    = jet_pkg::ST_WAIT_Y;
                end
            end
            jet_pkg::ST_WAIT_Y:
            begin
                cmd.div_sel_y = 1'b1;
                if (sts.div_done)
                begin
                    cmd.cap_im    = 1'b1;
                    cmd.init_left = 1'b1;
                    state_next    = jet_pkg::ST_MUL;
                end
            end
            jet_pkg::ST_MUL:
            begin
                if (sts.left_zero)
                    state_next = jet_pkg::ST_OUT;
                else
                begin
                    cmd.mul    = 1'b1;
                    state_next = jet_pkg::ST_UPD;
                end
            end
            jet_pkg::ST_UPD:
            begin
                if (sts.escaped)
                    state_next = jet_pkg::ST_OUT;
                else
                begin
                    cmd.upd    = 1'b1;
                    state_next = jet_pkg::ST_MUL;
                end
            end
            jet_pkg::ST_OUT:
            begin
                if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = jet_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = jet_pkg::ST_IDLE;
            end
        endcase
    end

    // result valid until taken
    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    localparam int CLK_PERIOD      = 4;
    localparam int FRAC_BITS       = jet_pkg::FRACTION_BITS_DEF;
    localparam int RG_STEP         = 36;
    localparam int B_STEP          = 85;
    localparam int PHASE_COUNT     = 8;
    localparam int ITEMS_PER_PHASE = 72;
    localparam int MAX_GAP         = 5;
    localparam int HOLD_CYCLES     = 2500;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int SETTLE_CYCLES   = 300;
    localparam int CFG_SLOTS       = 1 << jet_pkg::CFG_IDX_W;
    localparam int MAX_COORD_SPAN  = 1 << jet_pkg::COORD_W;

    localparam logic [jet_pkg::COORD_W-1:0] COORD_MAX = '1;
    localparam longint             WORD_MAX     = 64'sd2147483647;
    localparam longint             WORD_MIN     = -64'sd2147483648;
    localparam longint unsigned    ESCAPE_BOUND = 64'd4 << (2 * FRAC_BITS);

    // one escape result as seen on the result channel
    typedef struct {
        logic [jet_pkg::COORD_W-1:0]   x;
        logic [jet_pkg::COORD_W-1:0]   y;
        logic [jet_pkg::ITER_BITS-1:0] left;
        logic [jet_pkg::COLOR_W-1:0]   red;
        logic [jet_pkg::COLOR_W-1:0]   green;
        logic [jet_pkg::COLOR_W-1:0]   blue;
    } escape_result_t;

    // register shadow, escape-time predictor and queue of pending results
    class escape_ledger;
        longint                        c_re;
        longint                        c_im;
        logic [jet_pkg::ITER_BITS-1:0] budget;
        logic [jet_pkg::SIDE_W-1:0]    width;
        logic [jet_pkg::SIDE_W-1:0]    height;
        escape_result_t                awaited[$];
        int                            mismatches;

        function new();
            c_re       = jet_pkg::C_REAL_RST;
            c_im       = jet_pkg::C_IMAG_RST;
            budget     = jet_pkg::MAX_ITER_RST;
            width      = jet_pkg::WIDTH_RST;
            height     = jet_pkg::HEIGHT_RST;
            mismatches = 0;
        endfunction

        function void write_reg(jet_pkg::cfg_index_t idx,
                                logic [jet_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                jet_pkg::CFG_C_REAL:   c_re = signed'(data);
                jet_pkg::CFG_C_IMAG:   c_im = signed'(data);
                jet_pkg::CFG_MAX_ITER: budget = data[jet_pkg::ITER_BITS-1:0];
                jet_pkg::CFG_WIDTH:    width = data[jet_pkg::SIDE_W-1:0];
                jet_pkg::CFG_HEIGHT:   height = data[jet_pkg::SIDE_W-1:0];
                default:      ;
            endcase
        endfunction

        // saturate to the 32-bit word of z
        function longint clamp_word(longint v);
            if (v > WORD_MAX)
                return WORD_MAX;
            if (v < WORD_MIN)
                return WORD_MIN;
            return v;
        endfunction

        // pixel to start point, division truncates toward zero
        function longint start_point(logic [jet_pkg::COORD_W-1:0] p,
                                     logic [jet_pkg::SIDE_W-1:0] side, longint scale);
            longint s;
            longint d;
            s = side;
            if (s == 0)
                s = 1;
            d = p;
            d = d - s / 2;
            return clamp_word(scale * d * (longint'(1) << FRAC_BITS) / s);
        endfunction

        function escape_result_t predict_escape(logic [jet_pkg::COORD_W-1:0] x,
                                                logic [jet_pkg::COORD_W-1:0] y);
            escape_result_t                r;
            longint                        re;
            longint                        im;
            longint                        rr;
            longint                        ii;
            longint                        re_next;
            longint unsigned               mag;
            logic [jet_pkg::ITER_BITS-1:0] left;
            logic [jet_pkg::PAL_IDX_W-1:0] idx;
            re   = start_point(x, width, 3);
            im   = start_point(y, height, 2);
            left = budget;
            // z = z*z + c until |z|^2 reaches 4 or the budget is spent
            while (left != 0)
            begin
                rr  = re * re;
                ii  = im * im;
                mag = rr;
                mag = mag + ii;
                if (mag >= ESCAPE_BOUND)
                    break;
                re_next = clamp_word(((rr - ii) >>> FRAC_BITS) + c_re);
                im      = clamp_word(((re * im) >>> (FRAC_BITS - 1)) + c_im);
                re      = re_next;
                left--;
            end
            // palette from the low byte of the count: red bits 7:5, green 5:3, blue 1:0
            idx     = left[jet_pkg::PAL_IDX_W-1:0];
            r.x     = x;
            r.y     = y;
            r.left  = left;
            r.red   = jet_pkg::COLOR_W'(idx[7:5] * RG_STEP);
            r.green = jet_pkg::COLOR_W'(idx[5:3] * RG_STEP);
            r.blue  = jet_pkg::COLOR_W'(idx[1:0] * B_STEP);
            return r;
        endfunction

        function void note_pixel(logic [jet_pkg::COORD_W-1:0] x,
                                 logic [jet_pkg::COORD_W-1:0] y);
            awaited.insert(awaited.size(), predict_escape(x, y));
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(escape_result_t got);
            escape_result_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t: stray result, expected none, got pixel (%0d,%0d) left %0d",
                         $time, got.x, got.y, got.left);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            compare_field("out_x", want.x, got.x);
            compare_field("out_y", want.y, got.y);
            compare_field("iterations_left", want.left, got.left);
            compare_field("red", want.red, got.red);
            compare_field("green", want.green, got.green);
            compare_field("blue", want.blue, got.blue);
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    escape_ledger ledger;
    int           sender_gap_max;
    int           receiver_gap_max;
    bit           hold_request;
    int           quiet_cycles = 0;

    jet_pix_if pix ();
    jet_res_if res ();
    jet_cfg_if cfg ();

    julia_escape_time_pixel dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix),
        .res   (res),
        .cfg   (cfg)
    );

    // clock
    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // present one pixel and wait until the engine takes it
    task automatic send_pixel(logic [jet_pkg::COORD_W-1:0] x,
                              logic [jet_pkg::COORD_W-1:0] y);
        int gap;
        gap = $urandom_range(0, sender_gap_max);
        if (gap > 0)
        begin
            pix.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix.valid   <= 1'b1;
        pix.pixel_x <= x;
        pix.pixel_y <= y;
        do @(posedge clk); while (!pix.ready);
        ledger.note_pixel(x, y);
        @(negedge clk);
    endtask

    // one register write, valid dropped for a cycle afterwards
    task automatic write_reg(jet_pkg::cfg_index_t idx, logic [jet_pkg::CFG_DATA_W-1:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do @(posedge clk); while (!cfg.ready);
        ledger.write_reg(idx, data);
        @(negedge clk);
        cfg.valid <= 1'b0;
        @(negedge clk);
    endtask

    // all five registers, random junk above the narrow fields
    task automatic write_setting(logic [31:0] c_re, logic [31:0] c_im,
                                 logic [jet_pkg::ITER_BITS-1:0] budget,
                                 logic [jet_pkg::SIDE_W-1:0] w,
                                 logic [jet_pkg::SIDE_W-1:0] h);
        logic [jet_pkg::CFG_DATA_W-1:0] junk;
        junk = $urandom();
        write_reg(jet_pkg::CFG_C_REAL, c_re);
        write_reg(jet_pkg::CFG_C_IMAG, c_im);
        write_reg(jet_pkg::CFG_MAX_ITER, {junk[jet_pkg::CFG_DATA_W-1:jet_pkg::ITER_BITS], budget});
        write_reg(jet_pkg::CFG_WIDTH, {junk[jet_pkg::CFG_DATA_W-1:jet_pkg::SIDE_W], w});
        write_reg(jet_pkg::CFG_HEIGHT, {junk[jet_pkg::CFG_DATA_W-1:jet_pkg::SIDE_W], h});
    endtask

    // stop offering pixels and wait for every pending result
    task automatic drain_pixels();
        pix.valid <= 1'b0;
        @(negedge clk);
        while (ledger.awaited.size() != 0) @(negedge clk);
    endtask

    // mostly inside the image, sometimes any 14-bit value
    function automatic logic [jet_pkg::COORD_W-1:0] pick_coord(logic [jet_pkg::SIDE_W-1:0] side);
        logic [jet_pkg::COORD_W-1:0] c;
        int                          hi;
        c = jet_pkg::COORD_W'($urandom());
        if (side <= 1 || $urandom_range(0, 3) == 0)
            return c;
        hi = (side > MAX_COORD_SPAN) ? MAX_COORD_SPAN - 1 : side - 1;
        c  = jet_pkg::COORD_W'($urandom_range(0, hi));
        return c;
    endfunction

    // julia constant within about +-2
    function automatic logic [31:0] near_c();
        return $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
    endfunction

    // result side: random stalls, one long hold on request
    initial
    begin
        int             stall;
        escape_result_t got;
        res.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall        = hold_request ? HOLD_CYCLES : $urandom_range(0, receiver_gap_max);
            hold_request = 1'b0;
            if (stall > 0)
            begin
                res.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res.ready <= 1'b1;
            do @(posedge clk); while (!res.valid);
            got.x     = res.out_x;
            got.y     = res.out_y;
            got.left  = res.iterations_left;
            got.red   = res.red;
            got.green = res.green;
            got.blue  = res.blue;
            ledger.check_result(got);
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (!rst_n || (pix.valid && pix.ready) || (res.valid && res.ready) ||
            (cfg.valid && cfg.ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        ledger           = new();
        rst_n            = 1'b0;
        pix.valid        = 1'b0;
        pix.pixel_x      = '0;
        pix.pixel_y      = '0;
        cfg.valid        = 1'b0;
        cfg.index        = jet_pkg::CFG_C_REAL;
        cfg.data         = '0;
        sender_gap_max   = MAX_GAP;
        receiver_gap_max = MAX_GAP;
        hold_request     = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset values: corners, the center that never escapes, pixels outside the image
        send_pixel(0, 0);
        send_pixel(COORD_MAX, COORD_MAX);
        send_pixel(5000, 5000);
        send_pixel(9999, 0);
        send_pixel(0, 9999);
        drain_pixels();

        // zero image size with c at the negative extremes, writes to unused slots
        write_reg(jet_pkg::CFG_C_REAL, 32'h8000_0000);
        write_reg(jet_pkg::CFG_C_IMAG, 32'h8000_0000);
        write_reg(jet_pkg::CFG_MAX_ITER, '1);
        write_reg(jet_pkg::CFG_WIDTH, 32'hffff_8000);
        write_reg(jet_pkg::CFG_HEIGHT, 32'h0001_8000);
        for (int i = jet_pkg::CFG_HEIGHT + 1; i < CFG_SLOTS; i++)
            write_reg(jet_pkg::cfg_index_t'(i), $urandom());
        send_pixel(0, 0);
        send_pixel(1, 1);
        send_pixel(COORD_MAX, COORD_MAX);
        send_pixel(8191, 0);
        drain_pixels();

        // zero budget, widest and narrowest sides
        write_setting(0, 0, 0, '1, 1);
        send_pixel(0, 0);
        send_pixel(COORD_MAX, COORD_MAX);
        send_pixel(100, 0);
        drain_pixels();

        // c = 0 on a 2x2 image: the center point never escapes and spends the full budget
        write_setting(0, 0, '1, 2, 2);
        send_pixel(1, 1);
        send_pixel(0, 0);
        send_pixel(0, 1);
        send_pixel(1, 0);
        drain_pixels();

        // c at the positive extremes, the update saturates
        write_setting(32'h7fff_ffff, 32'h7fff_ffff, 3, 16384, 16384);
        send_pixel(0, 8192);
        send_pixel(8192, 8192);
        send_pixel(COORD_MAX, COORD_MAX);
        drain_pixels();

        // random phases, one setting each
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            sender_gap_max   = MAX_GAP;
            receiver_gap_max = MAX_GAP;
            case (phase)
                0:
                    write_setting(jet_pkg::C_REAL_RST, jet_pkg::C_IMAG_RST, 255,
                                  jet_pkg::SIDE_W'($urandom_range(2, 400)),
                                  jet_pkg::SIDE_W'($urandom_range(2, 400)));
                1:
                    write_setting(near_c(), near_c(), '1, 16384, 16384);
                2:
                begin
                    sender_gap_max   = 0;
                    receiver_gap_max = 0;
                    write_setting(near_c(), near_c(), 100,
                                  jet_pkg::SIDE_W'($urandom_range(2, 32767)),
                                  jet_pkg::SIDE_W'($urandom_range(2, 32767)));
                end
                3:
                begin
                    write_setting(near_c(), near_c(), 64,
                                  jet_pkg::SIDE_W'($urandom_range(2, 64)),
                                  jet_pkg::SIDE_W'($urandom_range(2, 64)));
                    hold_request = 1'b1;
                end
                4:
                    write_setting($urandom(), $urandom(),
                                  jet_pkg::ITER_BITS'($urandom()),
                                  jet_pkg::SIDE_W'($urandom()),
                                  jet_pkg::SIDE_W'($urandom()));
                5:
                begin
                    sender_gap_max = 0;
                    write_setting(jet_pkg::C_REAL_RST, jet_pkg::C_IMAG_RST,
                                  jet_pkg::MAX_ITER_RST, jet_pkg::WIDTH_RST,
                                  jet_pkg::HEIGHT_RST);
                end
                6:
                begin
                    receiver_gap_max = 0;
                    write_setting(jet_pkg::C_REAL_RST, jet_pkg::C_IMAG_RST, 256, 300, 300);
                end
                default:
                    write_setting(near_c(), near_c(),
                                  jet_pkg::ITER_BITS'($urandom_range(0, 1023)),
                                  jet_pkg::SIDE_W'($urandom_range(0, 3)),
                                  jet_pkg::SIDE_W'($urandom_range(0, 3)));
            endcase
            repeat (ITEMS_PER_PHASE)
                send_pixel(pick_coord(ledger.width), pick_coord(ledger.height));
            drain_pixels();
        end

        // let any stray result show up
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (ledger.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ files.f @@
design/jet_pkg.sv
design/jet_if.sv
design/jet_div.sv
design/jet_datapath.sv
design/jet_ctrl.sv
design/julia_escape_time_pixel.sv
bench/testbench.sv
